/* rtl/lrt_pkg.sv */
// Shared types and constants for the longest-remaining-time scheduler.
// No dependencies; imported by every rtl module and the checker.
`timescale 1ns / 1ps

package lrt_pkg;

  // Fixed field widths of the stream beats
  localparam int unsigned SLOT_FW     = 3;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned REM_W       = 16;
  localparam int unsigned STAT_W      = 24;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 88;

  // Parameter defaults
  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // Action codes carried on the input tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPD,
    ST_RESP
  } state_e;

  // One result beat
  typedef struct packed {
    logic [STAT_W-1:0]  turn;
    logic [STAT_W-1:0]  wait_cnt;
    logic [REM_W-1:0]   rem;
    logic               idle;
    logic [ID_W-1:0]    id;
    logic [SLOT_FW-1:0] slot;
  } res_t;

endpackage

/* rtl/lrt_table.sv */
// Slot table: one memory word per slot (id, remaining, waiting, turnaround),
// one write and one registered read port, per-entry valid bits. Uses lrt_pkg.
`timescale 1ns / 1ps

module lrt_table
  import lrt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned SLOT_W    = $clog2(SLOT_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [SLOT_W-1:0]     wr_addr_i,
  input  logic [ID_W-1:0]       wr_id_i,
  input  logic [REM_W-1:0]      wr_rem_i,
  input  logic [COUNT_BITS-1:0] wr_wait_i,
  input  logic [COUNT_BITS-1:0] wr_turn_i,
  input  logic [SLOT_W-1:0]     rd_addr_i,
  output logic [ID_W-1:0]       rd_id_o,
  output logic [REM_W-1:0]      rd_rem_o,
  output logic [COUNT_BITS-1:0] rd_wait_o,
  output logic [COUNT_BITS-1:0] rd_turn_o
);

  localparam int unsigned WORD_W = ID_W + REM_W + 2 * COUNT_BITS;

  logic [WORD_W-1:0]     mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  logic [WORD_W-1:0]     rd_q;
  logic                  rd_vld_q;
  logic [WORD_W-1:0]     rd_word;

  // Entry write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_turn_i, wr_wait_i, wr_rem_i, wr_id_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_word = rd_vld_q ? rd_q : '0;
  assign {rd_turn_o, rd_wait_o, rd_rem_o, rd_id_o} = rd_word;

endmodule

/* rtl/lrt_unit.sv */
// Shared compare and count unit, reused on every slot the sequencer visits:
// priority compare, decrement, saturating increments and 24-bit clipping.
`timescale 1ns / 1ps

module lrt_unit
  import lrt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [ID_W-1:0]       id_i,
  input  logic [REM_W-1:0]      rem_i,
  input  logic [COUNT_BITS-1:0] wait_i,
  input  logic [COUNT_BITS-1:0] turn_i,
  input  logic                  found_i,
  input  logic [REM_W-1:0]      best_rem_i,
  input  logic [ID_W-1:0]       best_id_i,
  output logic                  better_o,
  output logic [REM_W-1:0]      rem_dec_o,
  output logic [COUNT_BITS-1:0] wait_inc_o,
  output logic [COUNT_BITS-1:0] turn_inc_o,
  output logic [STAT_W-1:0]     wait_clip_o,
  output logic [STAT_W-1:0]     turn_clip_o
);

  // Larger remaining wins, lower id on a tie; empty slots never win
  assign better_o = (rem_i != '0) &&
                    (!found_i || (rem_i > best_rem_i) ||
                     ((rem_i == best_rem_i) && (id_i < best_id_i)));

  assign rem_dec_o  = rem_i - REM_W'(1);
  assign wait_inc_o = (&wait_i) ? wait_i : wait_i + COUNT_BITS'(1);
  assign turn_inc_o = (&turn_i) ? turn_i : turn_i + COUNT_BITS'(1);

  // Clip wide counters to the result field
  if (COUNT_BITS > STAT_W) begin : g_clip
    assign wait_clip_o = (|wait_i[COUNT_BITS-1:STAT_W]) ? '1 : wait_i[STAT_W-1:0];
    assign turn_clip_o = (|turn_i[COUNT_BITS-1:STAT_W]) ? '1 : turn_i[STAT_W-1:0];
  end else begin : g_ext
    assign wait_clip_o = STAT_W'(wait_i);
    assign turn_clip_o = STAT_W'(turn_i);
  end

endmodule

/* rtl/longest_remaining_time_scheduler.sv */
// Load: accept, response state, result register; read also reads the table.
// Tick: a scan pass over all slots finds the winner, an update pass updates
// counts (none when idle), one slot at a time via the single table read port
// and the shared compare unit. One item in flight; the next beat is taken once
// the result sits in the output register. Asynchronous active-low reset clears
// the sequencer, output valid and slot valid bits (table reads zero).
`timescale 1ns / 1ps

module longest_remaining_time_scheduler
  import lrt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [ACT_W-1:0]       s_axis_tuser_i,   // action
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // slot, process_id, burst
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic                   m_axis_tuser_o,   // idle
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // chosen_slot, chosen_id,
                                                   // remaining_after,
                                                   // waiting_time, turnaround_time
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  state_e state_q, state_d;

  logic [SLOT_FW-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0]  rd_idx_q, rd_addr;
  logic [SLOT_W-1:0]  best_q, best_d;
  logic [REM_W-1:0]   best_rem_q, best_rem_d;
  logic [ID_W-1:0]    best_id_q, best_id_d;
  logic               found_q, found_d;
  res_t               res_q, res_d;
  res_t               out_q;
  logic               out_vld_q;

  // Input beat fields
  action_e            in_act;
  logic [SLOT_FW-1:0] in_slot;
  logic [ID_W-1:0]    in_pid;
  logic [REM_W-1:0]   in_burst;
  logic               in_range;
  logic               s_acc;
  logic               out_free;
  logic               last;

  // Table ports
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [ID_W-1:0]       wr_id;
  logic [REM_W-1:0]      wr_rem;
  logic [COUNT_BITS-1:0] wr_wait, wr_turn;
  logic [ID_W-1:0]       rd_id;
  logic [REM_W-1:0]      rd_rem;
  logic [COUNT_BITS-1:0] rd_wait, rd_turn;

  // Shared unit results
  logic                  u_better;
  logic [REM_W-1:0]      u_rem_dec;
  logic [COUNT_BITS-1:0] u_wait_inc, u_turn_inc;
  logic [STAT_W-1:0]     u_wait_clip, u_turn_clip;

  assign in_act   = action_e'(s_axis_tuser_i);
  assign in_slot  = s_axis_tdata_i[SLOT_FW-1:0];
  assign in_pid   = s_axis_tdata_i[SLOT_FW+ID_W-1:SLOT_FW];
  assign in_burst = s_axis_tdata_i[SLOT_FW+ID_W+REM_W-1:SLOT_FW+ID_W];
  assign in_range = 32'(in_slot) < SLOT_COUNT;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign last            = (rd_idx_q == LAST_IDX);

  lrt_table #(
    .SLOT_COUNT(SLOT_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_id_i  (wr_id),
    .wr_rem_i (wr_rem),
    .wr_wait_i(wr_wait),
    .wr_turn_i(wr_turn),
    .rd_addr_i(rd_addr),
    .rd_id_o  (rd_id),
    .rd_rem_o (rd_rem),
    .rd_wait_o(rd_wait),
    .rd_turn_o(rd_turn)
  );

  lrt_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_unit (
    .id_i       (rd_id),
    .rem_i      (rd_rem),
    .wait_i     (rd_wait),
    .turn_i     (rd_turn),
    .found_i    (found_q),
    .best_rem_i (best_rem_q),
    .best_id_i  (best_id_q),
    .better_o   (u_better),
    .rem_dec_o  (u_rem_dec),
    .wait_inc_o (u_wait_inc),
    .turn_inc_o (u_turn_inc),
    .wait_clip_o(u_wait_clip),
    .turn_clip_o(u_turn_clip)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (in_act)
            ACT_TICK: state_d = ST_SCAN;
            ACT_READ: state_d = in_range ? ST_READ : ST_RESP;
            default:  state_d = ST_RESP;
          endcase
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_SCAN: begin
        if (last) begin
          state_d = (found_q || u_better) ? ST_UPD : ST_RESP;
        end
      end
      ST_UPD: begin
        if (last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table control per state
  always_comb begin
    slot_d     = slot_q;
    best_d     = best_q;
    best_rem_d = best_rem_q;
    best_id_d  = best_id_q;
    found_d    = found_q;
    res_d      = res_q;
    rd_addr    = last ? '0 : rd_idx_q + SLOT_W'(1);
    wr_en      = 1'b0;
    wr_addr    = rd_idx_q;
    wr_id      = rd_id;
    wr_rem     = rd_rem;
    wr_wait    = rd_wait;
    wr_turn    = rd_turn;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = (in_act == ACT_TICK) ? '0 : SLOT_W'(in_slot);
        wr_addr = SLOT_W'(in_slot);
        wr_id   = in_pid;
        wr_rem  = in_burst;
        wr_wait = '0;
        wr_turn = COUNT_BITS'(in_burst);
        if (s_acc) begin
          slot_d  = in_slot;
          found_d = 1'b0;
          res_d   = '0;
          unique case (in_act)
            ACT_LOAD: begin
              res_d.slot = in_slot;
              if (in_range) begin
                wr_en      = 1'b1;
                res_d.id   = in_pid;
                res_d.rem  = in_burst;
                res_d.turn = STAT_W'(in_burst);
              end
            end
            ACT_READ: res_d.slot = in_slot;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_d.slot     = slot_q;
        res_d.id       = rd_id;
        res_d.idle     = 1'b0;
        res_d.rem      = rd_rem;
        res_d.wait_cnt = u_wait_clip;
        res_d.turn     = u_turn_clip;
      end
      ST_SCAN: begin
        // Keep the best slot seen so far
        if (u_better) begin
          best_d     = rd_idx_q;
          best_rem_d = rd_rem;
          best_id_d  = rd_id;
          found_d    = 1'b1;
        end
        if (last && !(found_q || u_better)) begin
          res_d      = '0;
          res_d.idle = 1'b1;
        end
      end
      ST_UPD: begin
        // Run the winner one tick, age every other live slot
        if (rd_idx_q == best_q) begin
          wr_en          = 1'b1;
          wr_rem         = u_rem_dec;
          res_d.slot     = SLOT_FW'(best_q);
          res_d.id       = rd_id;
          res_d.idle     = 1'b0;
          res_d.rem      = u_rem_dec;
          res_d.wait_cnt = u_wait_clip;
          res_d.turn     = u_turn_clip;
        end else if (rd_rem != '0) begin
          wr_en   = 1'b1;
          wr_wait = u_wait_inc;
          wr_turn = u_turn_inc;
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (state_q == ST_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    rd_idx_q   <= rd_addr;
    best_q     <= best_d;
    best_rem_q <= best_rem_d;
    best_id_q  <= best_id_d;
    res_q      <= res_d;
    if (state_q == ST_RESP && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.idle;
  assign m_axis_tdata_o  = {5'b0, out_q.turn, out_q.wait_cnt, out_q.rem, out_q.id, out_q.slot};

endmodule

/* rtl/lrt_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
// Uses lrt_pkg for beat widths.
`timescale 1ns / 1ps

module lrt_checker
  import lrt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [ACT_W-1:0]       s_axis_tuser_i,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic                   m_axis_tuser_o,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // One item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // A new result only appears while an item was in flight
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result without an item in flight");

  // An idle tick reports zero in every other field
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("idle result carries data");

endmodule

bind longest_remaining_time_scheduler lrt_checker u_lrt_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for longest_remaining_time_scheduler.
// Depends on rtl/lrt_pkg.sv and rtl/longest_remaining_time_scheduler.sv;
// a directed table comes first, then random beats checked by a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import lrt_pkg::*;

  localparam int unsigned NUM_SLOTS   = SLOT_COUNT_DEF;
  localparam int unsigned WDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned RAND_BEATS  = 510;   // per idling phase, three phases
  localparam logic [STAT_W-1:0] CNT_SAT = '1;

  // One expected or observed result beat
  typedef struct packed {
    logic [STAT_W-1:0]  turn;
    logic [STAT_W-1:0]  wait_cnt;
    logic [REM_W-1:0]   rem;
    logic               idle;
    logic [ID_W-1:0]    id;
    logic [SLOT_FW-1:0] slot;
  } sched_res_t;

  // One row of the directed table
  typedef struct {
    action_e            act;
    logic [SLOT_FW-1:0] slot;
    logic [ID_W-1:0]    pid;
    logic [REM_W-1:0]   burst;
    bit                 typed;
    sched_res_t         want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic [ACT_W-1:0]       s_user = '0;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   m_ready = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_user;
  logic [OUT_TDATA_W-1:0] m_data;

  // Predictor state: one entry per slot
  logic [REM_W-1:0]  pend_work [NUM_SLOTS];
  logic [ID_W-1:0]   slot_pid  [NUM_SLOTS];
  logic [STAT_W-1:0] wait_ticks[NUM_SLOTS];
  logic [STAT_W-1:0] turn_ticks[NUM_SLOTS];

  sched_res_t sched_exp_q[$];
  dir_row_t   dir_tab[$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       rx_hold = 1'b0;
  int         quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  longest_remaining_time_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tuser_o  (m_user),
    .m_axis_tdata_o  (m_data)
  );

  function automatic sched_res_t mk_res(logic [SLOT_FW-1:0] slot, logic [ID_W-1:0] id,
                                        logic idle, logic [REM_W-1:0] rem,
                                        logic [STAT_W-1:0] w, logic [STAT_W-1:0] t);
    sched_res_t r;
    r.slot = slot; r.id = id; r.idle = idle; r.rem = rem; r.wait_cnt = w; r.turn = t;
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] sat_inc(logic [STAT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  function automatic void clear_table();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      pend_work[k] = '0; slot_pid[k] = '0; wait_ticks[k] = '0; turn_ticks[k] = '0;
    end
  endfunction

  // Advance the scheduler table by one accepted beat and return its result
  function automatic sched_res_t sched_predict(action_e act, logic [SLOT_FW-1:0] s,
                                               logic [ID_W-1:0] pid, logic [REM_W-1:0] burst);
    sched_res_t r;
    bit         found;
    int         best;
    r = '0;
    found = 1'b0;
    best = 0;
    case (act)
      ACT_LOAD, ACT_READ: begin
        if (act == ACT_LOAD) begin
          slot_pid[s]   = pid;
          pend_work[s]  = burst;
          wait_ticks[s] = '0;
          turn_ticks[s] = STAT_W'(burst);
        end
        r = mk_res(s, slot_pid[s], 1'b0, pend_work[s], wait_ticks[s], turn_ticks[s]);
      end
      ACT_TICK: begin
        // largest remaining wins, then lower id, then lower index
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (pend_work[k] != '0 &&
              (!found || pend_work[k] > pend_work[best] ||
               (pend_work[k] == pend_work[best] && slot_pid[k] < slot_pid[best]))) begin
            best = k;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.idle = 1'b1;
        end else begin
          pend_work[best] = pend_work[best] - 1'b1;
          for (int k = 0; k < NUM_SLOTS; k++) begin
            if (k != best && pend_work[k] != '0) begin
              wait_ticks[k] = sat_inc(wait_ticks[k]);
              turn_ticks[k] = sat_inc(turn_ticks[k]);
            end
          end
          r = mk_res(SLOT_FW'(best), slot_pid[best], 1'b0, pend_work[best],
                     wait_ticks[best], turn_ticks[best]);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [STAT_W-1:0] want,
                                      logic [STAT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Offer one beat, honouring sender idling; predict once accepted
  task automatic send_beat(action_e act, logic [SLOT_FW-1:0] slot, logic [ID_W-1:0] pid,
                           logic [REM_W-1:0] burst, bit typed, sched_res_t want);
    sched_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {5'd0, burst, pid, slot};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    r = sched_predict(act, slot, pid, burst);
    sched_exp_q.push_back(typed ? want : r);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sched_exp_q.size() != 0);
  endtask

  function automatic void add_row(action_e act, logic [SLOT_FW-1:0] slot,
                                  logic [ID_W-1:0] pid, logic [REM_W-1:0] burst,
                                  bit typed, sched_res_t want);
    dir_row_t row;
    row.act = act; row.slot = slot; row.pid = pid; row.burst = burst;
    row.typed = typed; row.want = want;
    dir_tab.push_back(row);
  endfunction

  // Receiver: random back-pressure, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (rx_hold) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    sched_res_t got;
    sched_res_t want;
    if (rst_n && m_valid && m_ready) begin
      got = mk_res(m_data[2:0], m_data[18:3], m_user, m_data[34:19],
                   m_data[58:35], m_data[82:59]);
      if (sched_exp_q.size() == 0) begin
        $error("result beat with nothing expected: slot %0d id %0h", got.slot, got.id);
        err_cnt++;
      end else begin
        want = sched_exp_q.pop_front();
        check_field("chosen_slot", STAT_W'(want.slot), STAT_W'(got.slot));
        check_field("chosen_id", STAT_W'(want.id), STAT_W'(got.id));
        check_field("idle", STAT_W'(want.idle), STAT_W'(got.idle));
        check_field("remaining_after", STAT_W'(want.rem), STAT_W'(got.rem));
        check_field("waiting_time", want.wait_cnt, got.wait_cnt);
        check_field("turnaround_time", want.turn, got.turn);
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sched_res_t  none_res;
    action_e     act;
    int          pick;
    logic [15:0] pid;
    logic [15:0] burst;
    none_res = '0;
    clear_table();

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset contents, idle tick, unused action, extremes, ties
    add_row(ACT_READ, 3'd0, 16'h0000, 16'h0000, 1'b1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b1, mk_res(0, 0, 1, 0, 0, 0));
    add_row(ACT_NONE, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1,
            mk_res(7, 16'hFFFF, 0, 16'hFFFF, 0, 24'h00FFFF));
    add_row(ACT_LOAD, 3'd0, 16'h0000, 16'h0000, 1'b1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b1,
            mk_res(7, 16'hFFFF, 0, 16'hFFFE, 0, 24'h00FFFF));
    add_row(ACT_READ, 3'd7, 16'h0000, 16'h0000, 1'b1,
            mk_res(7, 16'hFFFF, 0, 16'hFFFE, 0, 24'h00FFFF));
    add_row(ACT_LOAD, 3'd7, 16'h1234, 16'h0000, 1'b0, none_res);
    // equal remaining: lower id first, then lower slot on equal id
    add_row(ACT_LOAD, 3'd1, 16'd20, 16'd5, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd2, 16'd10, 16'd5, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd3, 16'd10, 16'd5, 1'b0, none_res);
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_READ, 3'd1, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_READ, 3'd2, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd4, 16'hAAAA, 16'h5555, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd5, 16'h5555, 16'hAAAA, 1'b0, none_res);
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_READ, 3'd4, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd5, 16'd3, 16'd0, 1'b0, none_res);
    add_row(ACT_LOAD, 3'd4, 16'd3, 16'd1, 1'b0, none_res);
    add_row(ACT_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0, none_res);
    add_row(ACT_NONE, 3'd2, 16'h0000, 16'h0000, 1'b1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(ACT_READ, 3'd6, 16'h0000, 16'h0000, 1'b0, none_res);

    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].act, dir_tab[i].slot, dir_tab[i].pid, dir_tab[i].burst,
                dir_tab[i].typed, dir_tab[i].want);
    end
    drain();

    // Random beats over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 34 : 0;
      for (int i = 0; i < RAND_BEATS; i++) begin
        // long receiver hold-off while the sender keeps offering
        if (i == 200 && phase != 1) begin
          fork
            begin
              rx_hold <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk_i);
              rx_hold <= 1'b0;
            end
          join_none
        end
        pick = $urandom_range(0, 99);
        act = (pick < 20) ? ACT_LOAD : (pick < 75) ? ACT_TICK :
              (pick < 95) ? ACT_READ : ACT_NONE;
        // small ids give frequent ties; mostly short bursts so slots drain
        pid = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        pick = $urandom_range(0, 99);
        burst = (pick < 85) ? 16'($urandom_range(0, 6)) :
                (pick < 97) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        send_beat(act, 3'($urandom_range(0, NUM_SLOTS - 1)), pid, burst, 1'b0, none_res);
      end
      // sender pause until everything outstanding has arrived
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sched_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", sched_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lrt_pkg.sv
rtl/lrt_table.sv
rtl/lrt_unit.sv
rtl/longest_remaining_time_scheduler.sv
rtl/lrt_checker.sv
test/tb_top.sv
